>>> rtl/core/ffib_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffib_pkg;

  // fixed field widths
  localparam int TIME_W = 11;
  localparam int TGT_W  = 4;
  localparam int CFG_W  = 5;

  // resources searched after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd1;

  // action codes
  localparam logic ACT_PRELOAD = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // one input transaction
  typedef struct packed {
    logic              action;
    logic [TGT_W-1:0]  target_resource;
    logic [TIME_W-1:0] start_minute;
    logic [TIME_W-1:0] end_minute;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic             granted;
    logic [TGT_W-1:0] resource_index;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ffib_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffib_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 512,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/ffib_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module ffib_engine #(
  parameter int MAX_RESOURCES = 16,
  parameter int BOOKINGS_PER_RESOURCE = 32,
  parameter int LIM_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire ffib_pkg::cmd_t   cmd,
  input  wire logic [LIM_W-1:0] limit,
  output logic                  busy,
  output logic                  result_valid,
  output ffib_pkg::result_t     result
);

  import ffib_pkg::*;

  localparam int DEPTH     = MAX_RESOURCES * BOOKINGS_PER_RESOURCE;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(BOOKINGS_PER_RESOURCE + 1);
  localparam int RES_CNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int RIDX_W    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int DATA_W    = 2 * TIME_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RES  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t               state;
  logic                 item_req;
  logic                 pre_ok;
  logic [TIME_W-1:0]    s_min;
  logic [TIME_W-1:0]    e_min;
  logic [RES_CNT_W-1:0] cur_res;
  logic [AW-1:0]        base;
  logic [CNT_W-1:0]     rd_ptr;
  logic                 pend;
  logic [CNT_W-1:0]     count [0:MAX_RESOURCES-1];

  logic [CNT_W-1:0]     n;
  logic                 full;
  logic                 in_range;
  logic                 issue;
  logic                 ovl;
  logic                 book;
  logic                 skip;
  logic                 no_fit;
  logic                 drop;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [DATA_W-1:0]    rdata;
  logic [TIME_W-1:0]    rd_start;
  logic [TIME_W-1:0]    rd_end;

  // interval table, start and end side by side
  ffib_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (book),
    .waddr (waddr),
    .wdata ({s_min, e_min}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_start = rdata[DATA_W-1:TIME_W];
  assign rd_end   = rdata[TIME_W-1:0];

  // current resource status
  assign n        = count[cur_res[RIDX_W-1:0]];
  assign full     = (n >= CNT_W'(BOOKINGS_PER_RESOURCE));
  assign in_range = (LIM_W'(cur_res) < limit);

  // shared compare: one booking per cycle, each read issued the cycle before its compare
  assign issue = (state == S_SCAN) && (rd_ptr < n);
  assign ovl   = pend && (s_min < rd_end) && (e_min > rd_start);
  assign raddr = base + AW'(rd_ptr);
  assign waddr = base + AW'(n);

  // sequencer decisions
  always_comb begin
    book   = 1'b0;
    skip   = 1'b0;
    no_fit = 1'b0;
    drop   = 1'b0;
    case (state)
      S_RES: begin
        if (!item_req) begin
          book = pre_ok && !full;
          drop = !(pre_ok && !full);
        end else if (!in_range) begin
          no_fit = 1'b1;
        end else if (full) begin
          skip = 1'b1;
        end else if (n == '0) begin
          book = 1'b1;
        end
      end
      S_SCAN: begin
        skip = ovl;
        book = !ovl && !issue && !pend;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          if (book || drop || no_fit) begin
            state <= S_IDLE;
          end else if (!skip) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (book) begin
            state <= S_IDLE;
          end else if (skip) begin
            state <= S_RES;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (book) begin
        count[cur_res[RIDX_W-1:0]] <= n + CNT_W'(1);
      end
      if ((book || no_fit) && item_req) begin
        result_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item_req <= (cmd.action == ACT_REQUEST);
      pre_ok   <= (LIM_W'(cmd.target_resource) < limit);
      s_min    <= cmd.start_minute;
      e_min    <= cmd.end_minute;
      if (cmd.action == ACT_REQUEST) begin
        cur_res <= '0;
        base    <= '0;
      end else begin
        cur_res <= RES_CNT_W'(cmd.target_resource);
        base    <= AW'(cmd.target_resource) * AW'(BOOKINGS_PER_RESOURCE);
      end
    end else if (skip) begin
      cur_res <= cur_res + RES_CNT_W'(1);
      base    <= base + AW'(BOOKINGS_PER_RESOURCE);
    end
    if (state == S_RES) begin
      rd_ptr <= '0;
      pend   <= 1'b0;
    end else begin
      if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      pend <= issue;
    end
    // result payload
    if (book) begin
      result.granted        <= 1'b1;
      result.resource_index <= TGT_W'(cur_res);
    end else if (no_fit) begin
      result.granted        <= 1'b0;
      result.resource_index <= '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_interval_booking_core.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit interval booking table. A transaction is taken when start is high
// and busy is low; busy stays high until its work is done. A preload adds its
// interval to the named resource if that resource is searched and not full,
// else drops it, and gives no result. A request walks resources from index
// zero, checking each stored booking of a resource against the new interval
// through a single compare unit fed by one read port of the interval memory,
// one booking per cycle. An empty or full resource is settled in S_RES alone,
// and one holding bookings is then scanned in S_SCAN, so a request takes
// longest when every resource is one short of full. The result appears on
// result for exactly one cycle with result_valid high, in the cycle busy
// falls; the receiver cannot stall it, so it must capture it then. The
// interval memory needs no clearing after reset, so the block is ready as
// soon as reset is released. cfg_data is written only while the block is
// idle and no transaction is offered on start.
module first_fit_interval_booking_core #(
  parameter int MAX_RESOURCES = 16,
  parameter int BOOKINGS_PER_RESOURCE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire ffib_pkg::cmd_t              cmd,
  output logic                             busy,
  output logic                             result_valid,
  output ffib_pkg::result_t                result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ffib_pkg::CFG_W-1:0]  cfg_data
);

  import ffib_pkg::*;

  localparam int RES_CNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int LIM_W     = (RES_CNT_W > CFG_W) ? RES_CNT_W : CFG_W;

  logic [CFG_W-1:0] resources_in_use;
  logic [LIM_W-1:0] limit;

  // configuration register
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      resources_in_use <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      resources_in_use <= cfg_data;
    end
  end

  // searched count, capped at the table size
  assign limit = (LIM_W'(resources_in_use) > LIM_W'(MAX_RESOURCES)) ?
                 LIM_W'(MAX_RESOURCES) : LIM_W'(resources_in_use);

  ffib_engine #(
    .MAX_RESOURCES         (MAX_RESOURCES),
    .BOOKINGS_PER_RESOURCE (BOOKINGS_PER_RESOURCE),
    .LIM_W                 (LIM_W)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .limit        (limit),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
  );

  // a result closes its transaction
  a_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while still busy");

  // an accepted transaction occupies the engine
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted but engine not busy");

  // a miss reports index zero
  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.granted) |-> (result.resource_index == '0))
    else $error("no grant with nonzero index");

  // a grant lies inside the searched range
  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.granted) |-> (LIM_W'(result.resource_index) < limit))
    else $error("grant outside searched resources");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ffib_pkg::*;

  localparam int NUM_RES = 16;
  localparam int SLOTS   = 32;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  cmd_t              cmd = '0;
  logic              busy;
  logic              result_valid;
  result_t           result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = CFG_RESET;

  first_fit_interval_booking_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // shadow copy of the booking table
  logic [TIME_W-1:0] shadow_start [NUM_RES][SLOTS];
  logic [TIME_W-1:0] shadow_end   [NUM_RES][SLOTS];
  int                shadow_count [NUM_RES];
  logic [CFG_W-1:0]  shadow_limit;

  cmd_t    pend_q[$];
  result_t grant_q[$];
  int      fail_count = 0;
  bit      took_cmd = 1'b0;

  // driver pacing
  int burst_left = 1;
  int gap_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // book one transaction into the shadow table if it fits; for a request, queue the expected result
  task automatic predict_booking(input cmd_t c);
    int      lim;
    int      n;
    bit      fits;
    result_t g;
    lim = (shadow_limit > NUM_RES) ? NUM_RES : int'(shadow_limit);
    if (c.action == ACT_PRELOAD) begin
      n = shadow_count[c.target_resource];
      if (int'(c.target_resource) < lim && n < SLOTS) begin
        shadow_start[c.target_resource][n] = c.start_minute;
        shadow_end[c.target_resource][n]   = c.end_minute;
        shadow_count[c.target_resource]    = n + 1;
      end
      return;
    end
    g = '0;
    for (int r = 0; r < lim; r++) begin
      n = shadow_count[r];
      fits = (n < SLOTS);
      for (int j = 0; j < n; j++) begin
        if (c.start_minute < shadow_end[r][j] && c.end_minute > shadow_start[r][j])
          fits = 1'b0;
      end
      if (fits) begin
        shadow_start[r][n] = c.start_minute;
        shadow_end[r][n]   = c.end_minute;
        shadow_count[r]    = n + 1;
        g.granted          = 1'b1;
        g.resource_index   = TGT_W'(r);
        break;
      end
    end
    grant_q.push_back(g);
  endtask

  // monitor: check results, track config writes and accepted transactions
  always @(posedge clk) begin : mon
    result_t want;
    took_cmd = 1'b0;
    if (rst) begin
      foreach (shadow_count[r]) shadow_count[r] = 0;
      shadow_limit = CFG_RESET;
    end else begin
      if (result_valid) begin
        if (grant_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: granted=%0b index=%0d",
                     result.granted, result.resource_index);
        end else begin
          want = grant_q.pop_front();
          if (result.granted !== want.granted ||
              result.resource_index !== want.resource_index) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected granted=%0b index=%0d, got granted=%0b index=%0d",
                       want.granted, want.resource_index,
                       result.granted, result.resource_index);
          end
        end
      end
      if (cfg_valid && cfg_ready)
        shadow_limit = cfg_data;
      if (start && !busy) begin
        took_cmd = 1'b1;
        predict_booking(cmd);
      end
    end
  end

  // driver: bursts of transactions with random gaps
  always @(negedge clk) begin : drv
    logic go;
    if (!rst && (!start || took_cmd)) begin
      if (start)
        void'(pend_q.pop_front());
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_q.size() > 0) begin
        go = 1'b1;
        cmd <= pend_q[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            8, 9:    gap_left = $urandom_range(6, 40);
            default: gap_left = $urandom_range(1, 5);
          endcase
        end else begin
          burst_left--;
        end
      end
      start <= go;
    end
  end

  function automatic cmd_t mk(logic act, int tgt, int s, int e);
    cmd_t c;
    c.action          = act;
    c.target_resource = TGT_W'(tgt);
    c.start_minute    = TIME_W'(s);
    c.end_minute      = TIME_W'(e);
    return c;
  endfunction

  // mostly well-formed intervals, often on a half-hour grid so they touch
  function automatic cmd_t rand_item(int lim);
    int  k;
    int  s;
    int  e;
    int  tgt;
    logic act;
    k = $urandom_range(0, 99);
    if (k < 10)
      return mk(1'($urandom_range(0, 1)), $urandom_range(0, 15),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
    act = (k < 72) ? ACT_REQUEST : ACT_PRELOAD;
    if (act == ACT_PRELOAD && lim > 0 && $urandom_range(0, 5) != 0)
      tgt = $urandom_range(0, lim - 1);
    else
      tgt = $urandom_range(0, 15);
    if ($urandom_range(0, 1) == 0) begin
      s = 30 * $urandom_range(0, 47);
      e = s + 30 * $urandom_range(0, 4);
    end else begin
      s = $urandom_range(0, 1439);
      e = s + $urandom_range(1, ($urandom_range(0, 3) == 0) ? 600 : 90);
    end
    if (e > 1440)
      e = 1440;
    return mk(act, tgt, s, e);
  endfunction

  // block idle: nothing queued, nothing expected, not busy
  task automatic wait_idle();
    while (pend_q.size() != 0 || start || grant_q.size() != 0 || busy)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] v, input int n, input bit fill);
    int lim;
    int tgt;
    int t;
    write_limit(v);
    lim = (v > NUM_RES) ? NUM_RES : int'(v);
    // stuff one resource past its capacity with zero-length preloads
    if (fill && lim > 0) begin
      tgt = $urandom_range(0, lim - 1);
      for (int i = 0; i < SLOTS + 2; i++) begin
        t = $urandom_range(0, 1440);
        pend_q.push_back(mk(ACT_PRELOAD, tgt, t, t));
      end
    end
    for (int i = 0; i < n; i++)
      pend_q.push_back(rand_item(lim));
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of one resource: extremes, touching, odd times
    pend_q.push_back(mk(ACT_REQUEST, 0, 0, 1440));
    pend_q.push_back(mk(ACT_REQUEST, 15, 1440, 1440));
    pend_q.push_back(mk(ACT_REQUEST, 0, 0, 0));
    pend_q.push_back(mk(ACT_REQUEST, 0, 100, 200));
    pend_q.push_back(mk(ACT_PRELOAD, 1, 10, 20));
    pend_q.push_back(mk(ACT_PRELOAD, 15, 10, 20));
    pend_q.push_back(mk(ACT_PRELOAD, 0, 2047, 2047));
    pend_q.push_back(mk(ACT_REQUEST, 0, 2000, 2047));
    pend_q.push_back(mk(ACT_REQUEST, 0, 1500, 100));

    // zero resources: every request denied, preload dropped
    write_limit(5'd0);
    pend_q.push_back(mk(ACT_REQUEST, 0, 300, 400));
    pend_q.push_back(mk(ACT_PRELOAD, 0, 5, 6));

    // limit above the table is clipped
    write_limit(5'd31);
    pend_q.push_back(mk(ACT_REQUEST, 5, 600, 660));
    pend_q.push_back(mk(ACT_REQUEST, 0, 660, 720));
    pend_q.push_back(mk(ACT_PRELOAD, 15, 0, 1440));
    pend_q.push_back(mk(ACT_REQUEST, 0, 0, 1440));
    pend_q.push_back(mk(ACT_REQUEST, 10, 2047, 0));
    pend_q.push_back(mk(ACT_REQUEST, 0, 1440, 2047));

    write_limit(5'd16);
    pend_q.push_back(mk(ACT_PRELOAD, 15, 1000, 1100));
    pend_q.push_back(mk(ACT_REQUEST, 0, 1050, 1060));
    pend_q.push_back(mk(ACT_REQUEST, 0, 0, 2047));

    // random phases, small limits first so the table fills gradually
    run_phase(5'd2, 120, 1'b1);
    run_phase(5'd5, 120, 1'b0);
    run_phase(5'd1, 60, 1'b0);
    run_phase(5'd0, 30, 1'b0);
    run_phase(5'd8, 130, 1'b1);
    run_phase(5'd3, 100, 1'b0);
    run_phase(5'd16, 150, 1'b0);
    run_phase(5'd20, 120, 1'b1);
    run_phase(5'd12, 100, 1'b0);
    run_phase(5'd31, 100, 1'b0);
    run_phase(5'd16, 60, 1'b0);

    wait_idle();
    if (grant_q.size() != 0)
      fail_count++;
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(30_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
